// ===== src/pews_pkg.sv =====
// Shared types and constants for the particle Euler wall step block.
package pews_pkg;

    localparam int unsigned DATA_W   = 32;
    localparam int unsigned ENERGY_W = 63;

    // Register indexes of the configuration port.
    localparam logic [2:0] REG_WALL_FLAGS    = 3'd0;
    localparam logic [2:0] REG_CELL_LOW_X    = 3'd1;
    localparam logic [2:0] REG_CELL_LOW_Y    = 3'd2;
    localparam logic [2:0] REG_CELL_WIDTH    = 3'd3;
    localparam logic [2:0] REG_CELL_HEIGHT   = 3'd4;
    localparam logic [2:0] REG_SPHERE_RADIUS = 3'd5;
    localparam logic [2:0] REG_TIME_STEP     = 3'd6;

    // Energy selection codes.
    localparam logic [1:0] ESEL_NONE    = 2'd0;
    localparam logic [1:0] ESEL_INITIAL = 2'd1;
    localparam logic [1:0] ESEL_FINAL   = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ENERGY,
        ST_DIV_X,
        ST_DIV_Y,
        ST_MUL_AX,
        ST_MUL_AY,
        ST_VEL,
        ST_MUL_PX,
        ST_MUL_PY,
        ST_POS,
        ST_OUT
    } pews_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic energy;
        logic div_start_x;
        logic div_start_y;
        logic div_step;
        logic mul_ax;
        logic mul_ay;
        logic vel;
        logic mul_px;
        logic mul_py;
        logic pos;
    } pews_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_done;
        logic energy_done;
    } pews_status_t;

endpackage

// ===== src/pews_ctrl.sv =====
// Controller state machine sequencing one particle through the datapath.
module pews_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  pews_pkg::pews_status_t status,
    output pews_pkg::pews_cmd_t    cmd
);

    pews_pkg::pews_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pews_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            pews_pkg::ST_IDLE:   if (in_valid) state_next = pews_pkg::ST_ENERGY;
            pews_pkg::ST_ENERGY: if (status.energy_done) state_next = pews_pkg::ST_DIV_X;
            pews_pkg::ST_DIV_X:  if (status.div_done) state_next = pews_pkg::ST_DIV_Y;
            pews_pkg::ST_DIV_Y:  if (status.div_done) state_next = pews_pkg::ST_MUL_AX;
            pews_pkg::ST_MUL_AX: state_next = pews_pkg::ST_MUL_AY;
            pews_pkg::ST_MUL_AY: state_next = pews_pkg::ST_VEL;
            pews_pkg::ST_VEL:    state_next = pews_pkg::ST_MUL_PX;
            pews_pkg::ST_MUL_PX: state_next = pews_pkg::ST_MUL_PY;
            pews_pkg::ST_MUL_PY: state_next = pews_pkg::ST_POS;
            pews_pkg::ST_POS:    state_next = pews_pkg::ST_OUT;
            pews_pkg::ST_OUT:    if (out_ready) state_next = pews_pkg::ST_IDLE;
            default:             state_next = pews_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd       = '0;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            pews_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            pews_pkg::ST_ENERGY: begin
                cmd.energy      = 1'b1;
                cmd.div_start_x = status.energy_done;
            end
            pews_pkg::ST_DIV_X: begin
                cmd.div_step    = 1'b1;
                cmd.div_start_y = status.div_done;
            end
            pews_pkg::ST_DIV_Y:  cmd.div_step = 1'b1;
            pews_pkg::ST_MUL_AX: cmd.mul_ax = 1'b1;
            pews_pkg::ST_MUL_AY: cmd.mul_ay = 1'b1;
            pews_pkg::ST_VEL:    cmd.vel = 1'b1;
            pews_pkg::ST_MUL_PX: cmd.mul_px = 1'b1;
            pews_pkg::ST_MUL_PY: cmd.mul_py = 1'b1;
            pews_pkg::ST_POS:    cmd.pos = 1'b1;
            pews_pkg::ST_OUT:    out_valid = 1'b1;
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

    a_accept_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && in_ready) |=> state_reg == pews_pkg::ST_ENERGY)
        else $error("item accepted outside idle");
    a_out_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped while stalled");
    a_no_both: assert property (@(posedge aclk) disable iff (!aresetn)
        !(in_ready && out_valid))
        else $error("ready and result at once");

endmodule

// ===== src/pews_datapath.sv =====
// Datapath: energy multiply-accumulate, shared restoring divider, multiplier and saturation.
module pews_datapath #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  pews_pkg::pews_cmd_t    cmd,
    output pews_pkg::pews_status_t status,
    input  logic [31:0]           in_pos_x,
    input  logic [31:0]           in_pos_y,
    input  logic [31:0]           in_vel_x,
    input  logic [31:0]           in_vel_y,
    input  logic [31:0]           in_force_x,
    input  logic [31:0]           in_force_y,
    input  logic [30:0]           in_mass,
    input  logic [1:0]            in_energy_select,
    input  logic [3:0]            wall_flags,
    input  logic signed [31:0]    cell_low_x,
    input  logic signed [31:0]    cell_low_y,
    input  logic [30:0]           cell_width,
    input  logic [30:0]           cell_height,
    input  logic [30:0]           sphere_radius,
    input  logic [30:0]           time_step,
    output logic [31:0]           new_pos_x,
    output logic [31:0]           new_pos_y,
    output logic [31:0]           new_vel_x,
    output logic [31:0]           new_vel_y,
    output logic [1:0]            move_x,
    output logic [1:0]            move_y,
    output logic [62:0]           energy_initial_total,
    output logic [62:0]           energy_final_total
);

    localparam int unsigned DIVN   = 32 + FRAC_BITS;
    localparam int unsigned DCNT_W = $clog2(DIVN + 1);
    localparam int unsigned ESHIFT = 2 * FRAC_BITS + 1;
    localparam logic signed [33:0] S_MAX = 34'sd2147483647;
    localparam logic signed [33:0] S_MIN = -34'sd2147483648;
    localparam logic signed [63:0] W_MAX = 64'sd2147483647;
    localparam logic signed [63:0] W_MIN = -64'sd2147483648;

    logic signed [31:0] px_reg, py_reg, vx_reg, vy_reg, fx_reg, fy_reg;
    logic [30:0] m_reg;
    logic [1:0]  esel_reg;
    logic [62:0] einit_reg, efinal_reg;

    // Energy: two 32x32 squares and two 32x31 partial products, one per cycle, accumulated exactly.
    logic [2:0]  ephase_reg;
    logic [63:0] sq_reg;
    logic [95:0] eacc_reg;
    logic [31:0] ax_mag, ay_mag;

    // Divider state.
    logic [DIVN-1:0]   dq_reg;
    logic [31:0]       drem_reg;
    logic [DCNT_W-1:0] dcnt_reg;
    logic              dneg_reg;
    logic signed [31:0] accx_reg, accy_reg;

    logic signed [63:0] prod_reg;
    logic signed [31:0] nvx_reg, nvy_reg;
    logic signed [31:0] npx_reg, npy_reg;

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        mag32 = v[31] ? 32'(-v) : 32'(v);
    endfunction

    function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
        if (v > S_MAX) sat34 = 32'sh7fffffff;
        else if (v < S_MIN) sat34 = 32'sh80000000;
        else sat34 = v[31:0];
    endfunction

    function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
        if (v > W_MAX) sat64 = 32'sh7fffffff;
        else if (v < W_MIN) sat64 = 32'sh80000000;
        else sat64 = v[31:0];
    endfunction

    // (a * dt) >> FRAC_BITS, truncated toward zero.
    function automatic logic signed [63:0] mulq(input logic signed [31:0] a,
                                                 input logic [30:0] b);
        logic [62:0] p;
        logic [63:0] s;
        p = 63'(mag32(a)) * 63'(b);
        s = 64'(p >> FRAC_BITS);
        mulq = a[31] ? -$signed(s) : $signed(s);
    endfunction

    function automatic logic [1:0] mcode(input logic signed [31:0] p,
                                         input logic signed [31:0] lo,
                                         input logic [30:0] ext);
        logic signed [33:0] hi;
        hi = 34'(lo) + $signed({3'b0, ext});
        if (p < lo) mcode = 2'b11;
        else if (34'(p) > hi) mcode = 2'b01;
        else mcode = 2'b00;
    endfunction

    assign ax_mag = mag32(vx_reg);
    assign ay_mag = mag32(vy_reg);

    logic [31:0] ppart;
    logic [63:0] pp;
    always_comb begin
        case (ephase_reg)
            3'd0: ppart = ax_mag;
            3'd1: ppart = ay_mag;
            3'd2: ppart = sq_reg[31:0];
            default: ppart = sq_reg[63:32];
        endcase
        if (ephase_reg < 3'd2) pp = 64'(ppart) * 64'(ppart);
        else pp = 64'(ppart) * 64'(m_reg);
    end

    logic [95:0] eshift;
    logic [62:0] ekin, esum_src;
    logic [63:0] esum;
    always_comb begin
        eshift = eacc_reg >> ESHIFT;
        ekin = (eshift[95:63] != '0) ? {63{1'b1}} : eshift[62:0];
        esum_src = (esel_reg == pews_pkg::ESEL_INITIAL) ? einit_reg : efinal_reg;
        esum = 64'(esum_src) + 64'(ekin);
    end

    assign status.energy_done = (ephase_reg == 3'd4);

    // Divider: one quotient bit a cycle.
    logic [32:0] dtrial;
    assign dtrial = {drem_reg, dq_reg[DIVN-1]} - {2'b0, m_reg};
    assign status.div_done = (dcnt_reg == DCNT_W'(DIVN));

    logic [DIVN-1:0] fq;
    logic signed [31:0] acc_val;
    always_comb begin
        if (dq_reg > DIVN'(33'h100000000)) fq = DIVN'(33'h100000000);
        else fq = dq_reg;
        acc_val = sat34(dneg_reg ? -$signed(34'(fq)) : $signed(34'(fq)));
    end

    logic [31:0] fsel;
    logic        fzero;
    assign fsel  = cmd.div_start_y ? mag32(fy_reg) : mag32(fx_reg);
    assign fzero = (fsel == '0);

    logic rx, ry;
    always_comb begin
        if (wall_flags[0]) rx = px_reg < $signed({1'b0, sphere_radius});
        else if (wall_flags[1])
            rx = (34'(px_reg) + $signed({3'b0, sphere_radius}))
                 > (34'(cell_low_x) + $signed({3'b0, cell_width}));
        else rx = 1'b0;
        if (wall_flags[2]) ry = py_reg < $signed({1'b0, sphere_radius});
        else if (wall_flags[3])
            ry = (34'(py_reg) + $signed({3'b0, sphere_radius}))
                 > (34'(cell_low_y) + $signed({3'b0, cell_height}));
        else ry = 1'b0;
    end

    logic signed [31:0] vx_sum, vy_sum;
    assign vx_sum = sat64(64'(vx_reg) + prod_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            einit_reg  <= '0;
            efinal_reg <= '0;
            ephase_reg <= '0;
        end else begin
            if (cmd.load) begin
                ephase_reg <= '0;
            end else if (cmd.energy && ephase_reg != 3'd4) begin
                ephase_reg <= ephase_reg + 3'd1;
            end
            if (cmd.energy && ephase_reg == 3'd4) begin
                if (esel_reg == pews_pkg::ESEL_INITIAL)
                    einit_reg <= esum[63] ? {63{1'b1}} : esum[62:0];
                else if (esel_reg == pews_pkg::ESEL_FINAL)
                    efinal_reg <= esum[63] ? {63{1'b1}} : esum[62:0];
            end
        end
    end

    assign vy_sum = sat64(64'(vy_reg) + prod_reg);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            px_reg   <= in_pos_x;
            py_reg   <= in_pos_y;
            vx_reg   <= in_vel_x;
            vy_reg   <= in_vel_y;
            fx_reg   <= in_force_x;
            fy_reg   <= in_force_y;
            m_reg    <= in_mass;
            esel_reg <= in_energy_select;
            sq_reg   <= '0;
            eacc_reg <= '0;
        end
        if (cmd.energy) begin
            case (ephase_reg)
                3'd0, 3'd1: sq_reg <= sq_reg + pp;
                3'd2: eacc_reg <= eacc_reg + 96'(pp);
                3'd3: eacc_reg <= eacc_reg + (96'(pp) << 32);
                default: eacc_reg <= eacc_reg;
            endcase
        end
        if (cmd.div_start_x || cmd.div_start_y) begin
            dq_reg   <= DIVN'(fsel) << FRAC_BITS;
            drem_reg <= '0;
            dcnt_reg <= '0;
            dneg_reg <= cmd.div_start_y ? fy_reg[31] : fx_reg[31];
            // Zero force or zero mass finish at once.
            if (fzero || m_reg == '0) begin
                dcnt_reg <= DCNT_W'(DIVN);
                dq_reg   <= fzero ? '0 : {DIVN{1'b1}};
            end
        end else if (cmd.div_step && !status.div_done) begin
            if (!dtrial[32]) begin
                drem_reg <= dtrial[31:0];
                dq_reg   <= {dq_reg[DIVN-2:0], 1'b1};
            end else begin
                drem_reg <= {drem_reg[30:0], dq_reg[DIVN-1]};
                dq_reg   <= {dq_reg[DIVN-2:0], 1'b0};
            end
            dcnt_reg <= dcnt_reg + DCNT_W'(1);
        end
        if (cmd.div_step && status.div_done) begin
            if (cmd.div_start_y) accx_reg <= acc_val;
            else accy_reg <= acc_val;
        end
        if (cmd.mul_ax) prod_reg <= mulq(accx_reg, time_step);
        if (cmd.mul_ay) begin
            nvx_reg  <= rx ? sat34(-34'(vx_sum)) : vx_sum;
            prod_reg <= mulq(accy_reg, time_step);
        end
        if (cmd.vel) nvy_reg <= ry ? sat34(-34'(vy_sum)) : vy_sum;
        if (cmd.mul_px) prod_reg <= mulq(nvx_reg, time_step);
        if (cmd.mul_py) begin
            npx_reg  <= sat64(64'(px_reg) + prod_reg);
            prod_reg <= mulq(nvy_reg, time_step);
        end
        if (cmd.pos) npy_reg <= sat64(64'(py_reg) + prod_reg);
    end

    assign new_pos_x = npx_reg;
    assign new_pos_y = npy_reg;
    assign new_vel_x = nvx_reg;
    assign new_vel_y = nvy_reg;
    assign move_x = mcode(npx_reg, cell_low_x, cell_width);
    assign move_y = mcode(npy_reg, cell_low_y, cell_height);
    assign energy_initial_total = einit_reg;
    assign energy_final_total   = efinal_reg;

    a_div_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        dcnt_reg <= DCNT_W'(DIVN) || !cmd.div_step)
        else $error("divider overran");
    a_energy_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        !cmd.load |=> einit_reg >= $past(einit_reg))
        else $error("initial energy decreased");
    a_energy_mono_f: assert property (@(posedge aclk) disable iff (!aresetn)
        !cmd.load |=> efinal_reg >= $past(efinal_reg))
        else $error("final energy decreased");

endmodule

// ===== src/particle_euler_wall_step.sv =====
// Top level: stream ports, configuration registers, controller and datapath.
//  channel | dir | handshake        | payload
//  s_      | in  | tvalid/tready    | tdata 232 bits, particle
//  m_      | out | tvalid/tready    | tdata 264 bits, result
//  apb     | in  | psel/penable     | 32-bit registers at 4*index
// Each item runs through the one-bit-a-cycle divider once per axis (Q16.16 at the
// default FRAC_BITS) and then waits out any output stall.
// An axis with zero force or zero mass skips its 32+FRAC_BITS divide steps.
// Reset clears the energy totals and the controller and sets the registers to their defaults.
// The next item is accepted only after the result is taken.
module particle_euler_wall_step #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // pos_x, pos_y, vel_x, vel_y, force_x, force_y, mass[30:0], energy_select[1:0], pad
    input  logic [231:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // new_pos_x, new_pos_y, new_vel_x, new_vel_y, move_x, move_y,
    // energy_initial_total, energy_final_total, pad
    output logic [263:0] m_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic [3:0]  wall_reg;
    logic [31:0] clx_reg, cly_reg;
    logic [30:0] cw_reg, ch_reg, rad_reg, dt_reg;
    logic [2:0]  ridx;
    logic        wr;

    assign pready = 1'b1;
    assign ridx   = paddr[4:2];
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wall_reg <= '0;
            clx_reg  <= '0;
            cly_reg  <= '0;
            cw_reg   <= 31'd65536;
            ch_reg   <= 31'd65536;
            rad_reg  <= '0;
            dt_reg   <= 31'd655;
        end else if (wr) begin
            case (ridx)
                pews_pkg::REG_WALL_FLAGS:    wall_reg <= pwdata[3:0];
                pews_pkg::REG_CELL_LOW_X:    clx_reg  <= pwdata;
                pews_pkg::REG_CELL_LOW_Y:    cly_reg  <= pwdata;
                pews_pkg::REG_CELL_WIDTH:    cw_reg   <= pwdata[30:0];
                pews_pkg::REG_CELL_HEIGHT:   ch_reg   <= pwdata[30:0];
                pews_pkg::REG_SPHERE_RADIUS: rad_reg  <= pwdata[30:0];
                pews_pkg::REG_TIME_STEP:     dt_reg   <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (ridx)
            pews_pkg::REG_WALL_FLAGS:    prdata = {28'b0, wall_reg};
            pews_pkg::REG_CELL_LOW_X:    prdata = clx_reg;
            pews_pkg::REG_CELL_LOW_Y:    prdata = cly_reg;
            pews_pkg::REG_CELL_WIDTH:    prdata = {1'b0, cw_reg};
            pews_pkg::REG_CELL_HEIGHT:   prdata = {1'b0, ch_reg};
            pews_pkg::REG_SPHERE_RADIUS: prdata = {1'b0, rad_reg};
            pews_pkg::REG_TIME_STEP:     prdata = {1'b0, dt_reg};
            default:                     prdata = '0;
        endcase
    end

    pews_pkg::pews_cmd_t    cmd;
    pews_pkg::pews_status_t status;
    logic [31:0] npx, npy, nvx, nvy;
    logic [1:0]  mx, my;
    logic [62:0] ei, ef;

    pews_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pews_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cmd                 (cmd),
        .status              (status),
        .in_pos_x            (s_tdata[31:0]),
        .in_pos_y            (s_tdata[63:32]),
        .in_vel_x            (s_tdata[95:64]),
        .in_vel_y            (s_tdata[127:96]),
        .in_force_x          (s_tdata[159:128]),
        .in_force_y          (s_tdata[191:160]),
        .in_mass             (s_tdata[222:192]),
        .in_energy_select    (s_tdata[224:223]),
        .wall_flags          (wall_reg),
        .cell_low_x          (clx_reg),
        .cell_low_y          (cly_reg),
        .cell_width          (cw_reg),
        .cell_height         (ch_reg),
        .sphere_radius       (rad_reg),
        .time_step           (dt_reg),
        .new_pos_x           (npx),
        .new_pos_y           (npy),
        .new_vel_x           (nvx),
        .new_vel_y           (nvy),
        .move_x              (mx),
        .move_y              (my),
        .energy_initial_total(ei),
        .energy_final_total  (ef)
    );

    assign m_tdata = {6'b0, ef, ei, my, mx, nvy, nvx, npy, npx};

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the particle Euler wall step block.
`timescale 1ns / 1ps

module testbench;

    localparam int  STALL_LIMIT = 5000;
    localparam int  DRAIN_WAIT  = 300;
    localparam longint SMAX = 64'sd2147483647;
    localparam longint SMIN = -64'sd2147483648;
    localparam logic [62:0] E_MAX = {63{1'b1}};

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic [30:0]        mass;
        logic [1:0]         esel;
    } particle_t;

    typedef struct packed {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] vel_x;
        logic [31:0] vel_y;
        logic [1:0]  move_x;
        logic [1:0]  move_y;
        logic [62:0] e_init;
        logic [62:0] e_final;
    } step_result_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    // pos_x, pos_y, vel_x, vel_y, force_x, force_y, mass[30:0], energy_select[1:0], pad
    logic [231:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    // new_pos_x, new_pos_y, new_vel_x, new_vel_y, move_x, move_y,
    // energy_initial_total, energy_final_total, pad
    logic [263:0] m_tdata;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [4:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    particle_euler_wall_step u_dut (.*);

    always #5 aclk = ~aclk;

    // Shadow copy of the block's registers and energy totals.
    logic [3:0]  wall_flags;
    longint      low_x, low_y, width, height, radius, dt;
    logic [62:0] init_total, final_total;

    particle_t    pending_items[$];
    step_result_t expected_results[$];
    int           errors = 0;
    int           idle_cycles = 0;

    function automatic void add_item(particle_t it);
        pending_items.insert(pending_items.size(), it);
    endfunction

    function automatic longint clamp32(longint v);
        if (v > SMAX) return SMAX;
        if (v < SMIN) return SMIN;
        return v;
    endfunction

    // Fixed-point product with truncation toward zero.
    function automatic longint fx_mul(longint a, longint b);
        longint mag;
        mag = (a < 0) ? -a : a;
        mag = (mag * b) >>> 16;
        return (a < 0) ? -mag : mag;
    endfunction

    function automatic longint accel(longint f, longint m);
        longint mag, q;
        mag = (f < 0) ? -f : f;
        if (mag == 0) return 0;
        if (m == 0) return (f < 0) ? SMIN : SMAX;
        q = (mag <<< 16) / m;
        if (q > 64'sd4294967296) q = 64'sd4294967296;
        return clamp32((f < 0) ? -q : q);
    endfunction

    function automatic logic [62:0] kinetic(longint vx, longint vy, longint m);
        logic [127:0] ax, ay, p;
        ax = (vx < 0) ? -vx : vx;
        ay = (vy < 0) ? -vy : vy;
        p = (ax * ax + ay * ay) * m;
        p = p >> 33;
        if (p > E_MAX) return E_MAX;
        return p[62:0];
    endfunction

    function automatic logic [62:0] add_total(logic [62:0] a, logic [62:0] b);
        logic [63:0] s;
        s = a + b;
        return s[63] ? E_MAX : s[62:0];
    endfunction

    function automatic logic [1:0] side_code(longint p, longint lo, longint ext);
        if (p < lo) return 2'b11;
        if (p > lo + ext) return 2'b01;
        return 2'b00;
    endfunction

    // Computes the result of one particle and updates the energy totals.
    function automatic step_result_t euler_step(particle_t it);
        step_result_t r;
        longint px, py, vx, vy, nvx, nvy, npx, npy, m;
        px = it.pos_x; py = it.pos_y; vx = it.vel_x; vy = it.vel_y;
        m = it.mass;
        if (it.esel == pews_pkg::ESEL_INITIAL)
            init_total = add_total(init_total, kinetic(vx, vy, m));
        else if (it.esel == pews_pkg::ESEL_FINAL)
            final_total = add_total(final_total, kinetic(vx, vy, m));
        nvx = clamp32(vx + fx_mul(accel(longint'(it.force_x), m), dt));
        nvy = clamp32(vy + fx_mul(accel(longint'(it.force_y), m), dt));
        // The low wall wins when both walls of an axis are flagged.
        if (wall_flags[0]) begin
            if (px < radius) nvx = clamp32(-nvx);
        end else if (wall_flags[1]) begin
            if (px + radius > low_x + width) nvx = clamp32(-nvx);
        end
        if (wall_flags[2]) begin
            if (py < radius) nvy = clamp32(-nvy);
        end else if (wall_flags[3]) begin
            if (py + radius > low_y + height) nvy = clamp32(-nvy);
        end
        npx = clamp32(px + fx_mul(nvx, dt));
        npy = clamp32(py + fx_mul(nvy, dt));
        r.pos_x = npx[31:0]; r.pos_y = npy[31:0];
        r.vel_x = nvx[31:0]; r.vel_y = nvy[31:0];
        r.move_x = side_code(npx, low_x, width);
        r.move_y = side_code(npy, low_y, height);
        r.e_init = init_total;
        r.e_final = final_total;
        return r;
    endfunction

    function automatic logic [231:0] pack_particle(particle_t it);
        return {7'd0, it.esel, it.mass, it.force_y, it.force_x,
                it.vel_y, it.vel_x, it.pos_y, it.pos_x};
    endfunction

    // Sender: bursts of random length separated by random gaps.
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge aclk) begin
        logic next_valid;
        particle_t it;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            next_valid = s_tvalid;
            if (s_tvalid && s_tready) begin
                it = pending_items.pop_front();
                expected_results.insert(expected_results.size(), euler_step(it));
                next_valid = 1'b0;
                if (burst_left > 0) burst_left--;
            end
            if (!next_valid && pending_items.size() > 0) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 12);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
                end else begin
                    next_valid = 1'b1;
                    s_tdata <= pack_particle(pending_items[0]);
                end
            end
            s_tvalid <= next_valid;
        end
    end

    // Receiver: the ready pattern switches between four modes, chosen at random.
    int cyc = 0;
    int stall_mode = 0;
    always @(posedge aclk) begin
        logic rdy;
        cyc++;
        if (cyc % 128 == 0) stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0: rdy = 1'b1;
            1: rdy = $urandom_range(0, 1);
            2: rdy = ($urandom_range(0, 7) == 0);
            default: rdy = ((cyc / 16) % 2 == 0);
        endcase
        m_tready <= rdy;
    end

    task automatic compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            errors++;
            if (errors <= 10)
                $display("mismatch %s: expected %h, got %h", name, exp_v, act_v);
        end
    endtask

    always @(posedge aclk) begin
        step_result_t exp_r, act_r;
        if (aresetn && m_tvalid && m_tready) begin
            act_r = {m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tdata[127:96],
                     m_tdata[129:128], m_tdata[131:130], m_tdata[194:132],
                     m_tdata[257:195]};
            if (expected_results.size() == 0) begin
                errors++;
                if (errors <= 10) $display("result with no item outstanding");
            end else begin
                exp_r = expected_results.pop_front();
                compare_field("new_pos_x", exp_r.pos_x, act_r.pos_x);
                compare_field("new_pos_y", exp_r.pos_y, act_r.pos_y);
                compare_field("new_vel_x", exp_r.vel_x, act_r.vel_x);
                compare_field("new_vel_y", exp_r.vel_y, act_r.vel_y);
                compare_field("move_x", exp_r.move_x, act_r.move_x);
                compare_field("move_y", exp_r.move_y, act_r.move_y);
                compare_field("energy_initial_total", exp_r.e_init, act_r.e_init);
                compare_field("energy_final_total", exp_r.e_final, act_r.e_final);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("** particle_euler_wall_step: FAILED **");
            $finish;
        end
    end

    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        @(posedge aclk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            pews_pkg::REG_WALL_FLAGS:    wall_flags = val[3:0];
            pews_pkg::REG_CELL_LOW_X:    low_x = longint'(signed'(val));
            pews_pkg::REG_CELL_LOW_Y:    low_y = longint'(signed'(val));
            pews_pkg::REG_CELL_WIDTH:    width = longint'(val[30:0]);
            pews_pkg::REG_CELL_HEIGHT:   height = longint'(val[30:0]);
            pews_pkg::REG_SPHERE_RADIUS: radius = longint'(val[30:0]);
            pews_pkg::REG_TIME_STEP:     dt = longint'(val[30:0]);
            default: ;
        endcase
    endtask

    // Waits until the block holds nothing, then lets the latency pass.
    task automatic drain();
        while (pending_items.size() > 0 || s_tvalid || expected_results.size() > 0)
            @(posedge aclk);
        repeat (150) @(posedge aclk);
    endtask

    task automatic configure(logic [3:0] wf, logic [31:0] lx, logic [31:0] ly,
                             logic [30:0] w, logic [30:0] h, logic [30:0] rad,
                             logic [30:0] step);
        drain();
        reg_write(pews_pkg::REG_WALL_FLAGS, 32'(wf));
        reg_write(pews_pkg::REG_CELL_LOW_X, lx);
        reg_write(pews_pkg::REG_CELL_LOW_Y, ly);
        reg_write(pews_pkg::REG_CELL_WIDTH, 32'(w));
        reg_write(pews_pkg::REG_CELL_HEIGHT, 32'(h));
        reg_write(pews_pkg::REG_SPHERE_RADIUS, 32'(rad));
        reg_write(pews_pkg::REG_TIME_STEP, 32'(step));
    endtask

    function automatic logic [31:0] rand_scaled();
        logic [31:0] v;
        v = $urandom >> $urandom_range(0, 31);
        return $urandom_range(0, 1) ? -v : v;
    endfunction

    // Mostly particles near the cell with moderate values, some pure noise.
    function automatic particle_t rand_particle();
        particle_t it;
        if ($urandom_range(0, 4) == 0) begin
            it = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  31'($urandom), 2'($urandom)};
        end else begin
            it.pos_x = 32'(low_x - radius + $urandom_range(0, 1023) *
                           ((width + 2 * radius) / 1000 + 1));
            it.pos_y = 32'(low_y - radius + $urandom_range(0, 1023) *
                           ((height + 2 * radius) / 1000 + 1));
            it.vel_x = rand_scaled();
            it.vel_y = rand_scaled();
            it.force_x = rand_scaled();
            it.force_y = rand_scaled();
            it.mass = ($urandom_range(0, 15) == 0) ? 31'd0 : 31'($urandom >> $urandom_range(1, 31));
            it.esel = 2'($urandom_range(0, 3));
        end
        return it;
    endfunction

    initial begin
        particle_t it;
        wall_flags = 4'd0; low_x = 0; low_y = 0; width = 65536; height = 65536;
        radius = 0; dt = 655; init_total = '0; final_total = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed items under the reset settings.
        add_item({32'sd100, 32'sd200, 32'sd65536, -32'sd65536,
                  32'sd65536, -32'sd65536, 31'd65536, pews_pkg::ESEL_NONE});
        add_item({32'sd0, 32'sd0, 32'sd0, 32'sd0,
                  32'sd1000, -32'sd1000, 31'd0, pews_pkg::ESEL_INITIAL});
        add_item({32'sd0, 32'sd0, 32'sd0, 32'sd0,
                  32'sd0, 32'sd0, 31'd0, pews_pkg::ESEL_FINAL});
        add_item({32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff,
                  32'h80000000, 32'h7fffffff, 31'h7fffffff, pews_pkg::ESEL_INITIAL});
        add_item({32'h80000000, 32'h7fffffff, 32'h80000000, 32'h80000000,
                  32'h7fffffff, 32'h80000000, 31'd1, pews_pkg::ESEL_FINAL});
        add_item({32'sd5, 32'sd5, 32'sd12345, 32'sd54321,
                  32'sd7, 32'sd9, 31'd3, 2'd3});

        // Both walls of each axis flagged; most negative velocity reflected.
        configure(4'hf, 32'h0, 32'h0, 31'd65536, 31'd65536, 31'd4096, 31'd655);
        add_item({32'sd100, 32'sd100, 32'h80000000, 32'h80000000,
                  32'sd0, 32'sd0, 31'd65536, pews_pkg::ESEL_NONE});
        add_item({32'sd70000, 32'sd70000, 32'sd65536, 32'sd65536,
                  32'sd0, 32'sd0, 31'd65536, pews_pkg::ESEL_INITIAL});
        configure(4'ha, 32'hffff0000, 32'hfffe0000, 31'd131072, 31'd196608, 31'd8192, 31'd6554);
        add_item({32'sd70000, 32'sd130000, 32'sd65536, 32'h80000000,
                  32'sd65536, 32'sd0, 31'd0, pews_pkg::ESEL_FINAL});
        add_item({32'sd4096, 32'sd4096, 32'sd1, -32'sd1,
                  -32'sd65536, 32'sd65536, 31'd32768, pews_pkg::ESEL_NONE});
        configure(4'h5, 32'h80000000, 32'h80000000, 31'h7fffffff, 31'h7fffffff,
                  31'h7fffffff, 31'h7fffffff);
        add_item({32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
                  32'h7fffffff, 32'h80000000, 31'd0, pews_pkg::ESEL_INITIAL});
        add_item({32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff,
                  32'h80000000, 32'h7fffffff, 31'd1, pews_pkg::ESEL_FINAL});

        // Random phases, each under its own setting.
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: configure(4'h0, 32'h0, 32'h0, 31'd65536, 31'd65536, 31'd0, 31'd655);
                1: configure(4'h5, 32'h0, 32'h0, 31'd655360, 31'd327680, 31'd6554, 31'd3277);
                2: configure(4'ha, $urandom, $urandom, 31'($urandom), 31'($urandom),
                             31'($urandom >> 8), 31'($urandom >> 10));
                3: configure(4'($urandom), 32'hfff00000, 32'h00100000, 31'd1, 31'd1,
                             31'd0, 31'd0);
                4: configure(4'hf, $urandom, $urandom, 31'($urandom), 31'($urandom),
                             31'($urandom), 31'($urandom));
                default: configure(4'($urandom), 32'h0, 32'h0, 31'd65536, 31'd65536,
                                   31'd655, 31'd65536);
            endcase
            for (int k = 0; k < 80; k++) begin
                it = rand_particle();
                add_item(it);
            end
        end

        drain();
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("** particle_euler_wall_step: PASSED **");
        end else begin
            $display("** particle_euler_wall_step: FAILED **");
        end
        $finish;
    end

endmodule
